// ----- hdl/lrk_pkg.sv -----
// Shared types, constants and the step microprogram of the Lorenz RK4 unit.
// No dependencies; every other file but lrk_req_if uses this package.
`default_nettype none

package lrk_pkg;

   // Fixed point format: signed Q16.32 in a 48-bit word.
   localparam int WORD_BITS      = 48;
   localparam int FRAC_BITS      = 32;
   localparam int STEP_BITS      = 47;
   localparam int HALF_BITS      = WORD_BITS / 2;
   localparam int HI_BITS        = WORD_BITS - HALF_BITS;
   localparam int PROD_BITS      = 2 * WORD_BITS;
   // Divide-by-six operand: word plus offset, rounded up to whole nibbles.
   localparam int DIV_BITS       = ((WORD_BITS + 5) / 4) * 4;
   localparam int DIV_STEPS      = DIV_BITS / 4;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS + 1);
   localparam int RF_DEPTH       = 16;
   localparam int RF_ADDR_BITS   = $clog2(RF_DEPTH);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = WORD_BITS;
   localparam int PROG_LEN       = 80;
   localparam int PC_BITS        = $clog2(PROG_LEN);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [STEP_BITS-1:0]        step_type;

   localparam word_type WORD_MAX = word_type'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam word_type WORD_MIN = word_type'({1'b1, {(WORD_BITS-1){1'b0}}});

   // Register defaults: h = 0.0001, init = (0, 1, 0), sigma 10, rho 28, beta 8/3.
   localparam step_type RST_STEP_SIZE = step_type'(64'd429497);
   localparam word_type RST_INIT_X    = word_type'(64'sd0);
   localparam word_type RST_INIT_Y    = word_type'(64'sd4294967296);
   localparam word_type RST_INIT_Z    = word_type'(64'sd0);
   localparam word_type RST_SIGMA     = word_type'(64'sd42949672960);
   localparam word_type RST_RHO       = word_type'(64'sd120259084288);
   localparam word_type RST_BETA      = word_type'(64'sd11453246123);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_SIZE = 3'd0,
      CSR_INIT_X    = 3'd1,
      CSR_INIT_Y    = 3'd2,
      CSR_INIT_Z    = 3'd3,
      CSR_SIGMA     = 3'd4,
      CSR_RHO       = 3'd5,
      CSR_BETA      = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      OPC_ADD   = 3'd0,
      OPC_SUB   = 3'd1,
      OPC_MUL   = 3'd2,
      OPC_HALF  = 3'd3,
      OPC_SIXTH = 3'd4
   } opc_type;

   // Operand / destination locations. Codes below LOC_POSX are register file slots.
   typedef enum logic [4:0] {
      LOC_PX    = 5'd0,
      LOC_PY    = 5'd1,
      LOC_PZ    = 5'd2,
      LOC_T0    = 5'd3,
      LOC_T1    = 5'd4,
      LOC_T2    = 5'd5,
      LOC_T3    = 5'd6,
      LOC_KX    = 5'd7,
      LOC_KY    = 5'd8,
      LOC_KZ    = 5'd9,
      LOC_SX    = 5'd10,
      LOC_SY    = 5'd11,
      LOC_SZ    = 5'd12,
      LOC_CX    = 5'd13,
      LOC_CY    = 5'd14,
      LOC_CZ    = 5'd15,
      LOC_POSX  = 5'd16,
      LOC_POSY  = 5'd17,
      LOC_POSZ  = 5'd18,
      LOC_SIGMA = 5'd19,
      LOC_RHO   = 5'd20,
      LOC_BETA  = 5'd21,
      LOC_H     = 5'd22
   } loc_type;

   typedef struct packed {
      opc_type opc;
      loc_type src_a;
      loc_type src_b;
      loc_type dst;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_ISSUE = 3'd1,
      ST_EXEC  = 3'd2,
      ST_WAIT  = 3'd3,
      ST_DONE  = 3'd4
   } state_type;

   typedef enum logic [2:0] {
      MP_IDLE = 3'd0,
      MP_LO   = 3'd1,
      MP_HI   = 3'd2,
      MP_SUM  = 3'd3,
      MP_OUT  = 3'd4
   } mul_phase_type;

   typedef struct packed {
      logic                    rd_en;
      logic [RF_ADDR_BITS-1:0] raddr_a;
      logic [RF_ADDR_BITS-1:0] raddr_b;
      logic                    we;
      logic [RF_ADDR_BITS-1:0] waddr;
   } rf_ctl_type;

   function automatic logic is_rf_loc(loc_type loc);
      return loc < LOC_POSX;
   endfunction

   // One RK4 step. Stage 0 reads the state directly and leaves k1 in S;
   // stage 1 adds 2*k2 to S; stage 2 keeps 2*k3 in C; stage 3 finishes.
   localparam uop_type PROG [PROG_LEN] = '{
      // stage 0: derivatives at the state
      '{OPC_SUB,   LOC_POSY,  LOC_POSX, LOC_T0},
      '{OPC_MUL,   LOC_SIGMA, LOC_T0,   LOC_T0},
      '{OPC_SUB,   LOC_RHO,   LOC_POSZ, LOC_T1},
      '{OPC_MUL,   LOC_POSX,  LOC_T1,   LOC_T1},
      '{OPC_SUB,   LOC_T1,    LOC_POSY, LOC_T1},
      '{OPC_MUL,   LOC_POSX,  LOC_POSY, LOC_T2},
      '{OPC_MUL,   LOC_BETA,  LOC_POSZ, LOC_T3},
      '{OPC_SUB,   LOC_T2,    LOC_T3,   LOC_T2},
      '{OPC_MUL,   LOC_H,     LOC_T0,   LOC_SX},
      '{OPC_MUL,   LOC_H,     LOC_T1,   LOC_SY},
      '{OPC_MUL,   LOC_H,     LOC_T2,   LOC_SZ},
      '{OPC_HALF,  LOC_SX,    LOC_SX,   LOC_T0},
      '{OPC_ADD,   LOC_POSX,  LOC_T0,   LOC_PX},
      '{OPC_HALF,  LOC_SY,    LOC_SY,   LOC_T0},
      '{OPC_ADD,   LOC_POSY,  LOC_T0,   LOC_PY},
      '{OPC_HALF,  LOC_SZ,    LOC_SZ,   LOC_T0},
      '{OPC_ADD,   LOC_POSZ,  LOC_T0,   LOC_PZ},
      // stage 1
      '{OPC_SUB,   LOC_PY,    LOC_PX,   LOC_T0},
      '{OPC_MUL,   LOC_SIGMA, LOC_T0,   LOC_T0},
      '{OPC_SUB,   LOC_RHO,   LOC_PZ,   LOC_T1},
      '{OPC_MUL,   LOC_PX,    LOC_T1,   LOC_T1},
      '{OPC_SUB,   LOC_T1,    LOC_PY,   LOC_T1},
      '{OPC_MUL,   LOC_PX,    LOC_PY,   LOC_T2},
      '{OPC_MUL,   LOC_BETA,  LOC_PZ,   LOC_T3},
      '{OPC_SUB,   LOC_T2,    LOC_T3,   LOC_T2},
      '{OPC_MUL,   LOC_H,     LOC_T0,   LOC_KX},
      '{OPC_MUL,   LOC_H,     LOC_T1,   LOC_KY},
      '{OPC_MUL,   LOC_H,     LOC_T2,   LOC_KZ},
      '{OPC_HALF,  LOC_KX,    LOC_KX,   LOC_T0},
      '{OPC_ADD,   LOC_POSX,  LOC_T0,   LOC_PX},
      '{OPC_HALF,  LOC_KY,    LOC_KY,   LOC_T0},
      '{OPC_ADD,   LOC_POSY,  LOC_T0,   LOC_PY},
      '{OPC_HALF,  LOC_KZ,    LOC_KZ,   LOC_T0},
      '{OPC_ADD,   LOC_POSZ,  LOC_T0,   LOC_PZ},
      '{OPC_ADD,   LOC_KX,    LOC_KX,   LOC_T0},
      '{OPC_ADD,   LOC_SX,    LOC_T0,   LOC_SX},
      '{OPC_ADD,   LOC_KY,    LOC_KY,   LOC_T0},
      '{OPC_ADD,   LOC_SY,    LOC_T0,   LOC_SY},
      '{OPC_ADD,   LOC_KZ,    LOC_KZ,   LOC_T0},
      '{OPC_ADD,   LOC_SZ,    LOC_T0,   LOC_SZ},
      // stage 2
      '{OPC_SUB,   LOC_PY,    LOC_PX,   LOC_T0},
      '{OPC_MUL,   LOC_SIGMA, LOC_T0,   LOC_T0},
      '{OPC_SUB,   LOC_RHO,   LOC_PZ,   LOC_T1},
      '{OPC_MUL,   LOC_PX,    LOC_T1,   LOC_T1},
      '{OPC_SUB,   LOC_T1,    LOC_PY,   LOC_T1},
      '{OPC_MUL,   LOC_PX,    LOC_PY,   LOC_T2},
      '{OPC_MUL,   LOC_BETA,  LOC_PZ,   LOC_T3},
      '{OPC_SUB,   LOC_T2,    LOC_T3,   LOC_T2},
      '{OPC_MUL,   LOC_H,     LOC_T0,   LOC_KX},
      '{OPC_MUL,   LOC_H,     LOC_T1,   LOC_KY},
      '{OPC_MUL,   LOC_H,     LOC_T2,   LOC_KZ},
      '{OPC_ADD,   LOC_POSX,  LOC_KX,   LOC_PX},
      '{OPC_ADD,   LOC_POSY,  LOC_KY,   LOC_PY},
      '{OPC_ADD,   LOC_POSZ,  LOC_KZ,   LOC_PZ},
      '{OPC_ADD,   LOC_KX,    LOC_KX,   LOC_CX},
      '{OPC_ADD,   LOC_KY,    LOC_KY,   LOC_CY},
      '{OPC_ADD,   LOC_KZ,    LOC_KZ,   LOC_CZ},
      // stage 3 and state update
      '{OPC_SUB,   LOC_PY,    LOC_PX,   LOC_T0},
      '{OPC_MUL,   LOC_SIGMA, LOC_T0,   LOC_T0},
      '{OPC_SUB,   LOC_RHO,   LOC_PZ,   LOC_T1},
      '{OPC_MUL,   LOC_PX,    LOC_T1,   LOC_T1},
      '{OPC_SUB,   LOC_T1,    LOC_PY,   LOC_T1},
      '{OPC_MUL,   LOC_PX,    LOC_PY,   LOC_T2},
      '{OPC_MUL,   LOC_BETA,  LOC_PZ,   LOC_T3},
      '{OPC_SUB,   LOC_T2,    LOC_T3,   LOC_T2},
      '{OPC_MUL,   LOC_H,     LOC_T0,   LOC_KX},
      '{OPC_MUL,   LOC_H,     LOC_T1,   LOC_KY},
      '{OPC_MUL,   LOC_H,     LOC_T2,   LOC_KZ},
      '{OPC_ADD,   LOC_CX,    LOC_KX,   LOC_CX},
      '{OPC_ADD,   LOC_CY,    LOC_KY,   LOC_CY},
      '{OPC_ADD,   LOC_CZ,    LOC_KZ,   LOC_CZ},
      '{OPC_ADD,   LOC_SX,    LOC_CX,   LOC_SX},
      '{OPC_ADD,   LOC_SY,    LOC_CY,   LOC_SY},
      '{OPC_ADD,   LOC_SZ,    LOC_CZ,   LOC_SZ},
      '{OPC_SIXTH, LOC_SX,    LOC_SX,   LOC_SX},
      '{OPC_SIXTH, LOC_SY,    LOC_SY,   LOC_SY},
      '{OPC_SIXTH, LOC_SZ,    LOC_SZ,   LOC_SZ},
      '{OPC_ADD,   LOC_POSX,  LOC_SX,   LOC_POSX},
      '{OPC_ADD,   LOC_POSY,  LOC_SY,   LOC_POSY},
      '{OPC_ADD,   LOC_POSZ,  LOC_SZ,   LOC_POSZ}
   };

endpackage

`default_nettype wire

// ----- hdl/lrk_req_if.sv -----
// Request channel: valid/ready handshake carrying the restart flag.
// Depends on nothing but the handshake convention.
`default_nettype none

interface lrk_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ----- hdl/lrk_rsp_if.sv -----
// Response channel: valid/ready handshake carrying the stepped state word.
// Depends on lrk_pkg for the word type.
`default_nettype none

interface lrk_rsp_if;
   import lrk_pkg::*;

   logic     valid;
   logic     ready;
   word_type x_out;
   word_type y_out;
   word_type z_out;
   logic     overflow;

   modport source (output valid, output x_out, output y_out, output z_out,
                   output overflow, input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out,
                   input overflow, output ready);
endinterface

`default_nettype wire

// ----- hdl/lrk_regfile.sv -----
// Scratch register file: 16 words, one write port, two registered read ports.
// Depends on lrk_pkg.
`default_nettype none

module lrk_regfile (
   input  wire logic                clock,
   input  wire lrk_pkg::rf_ctl_type ctl,
   input  wire lrk_pkg::word_type   wdata,
   output lrk_pkg::word_type        rdata_a,
   output lrk_pkg::word_type        rdata_b
);
   import lrk_pkg::*;

   word_type mem [RF_DEPTH];
   word_type rdata_a_ff;
   word_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_a_ff <= mem[ctl.raddr_a];
         rdata_b_ff <= mem[ctl.raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ----- hdl/lrk_mul.sv -----
// Fixed point multiplier: two half-width partial products, sum, round, saturate.
// Depends on lrk_pkg. Result and done are valid in the MP_OUT phase.
`default_nettype none

module lrk_mul (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire lrk_pkg::word_type opnd_a,
   input  wire lrk_pkg::word_type opnd_b,
   output logic                   done,
   output lrk_pkg::word_type      result,
   output logic                   sat
);
   import lrk_pkg::*;

   mul_phase_type phase_ff, phase_in;

   word_type a_ff;
   word_type b_ff;
   logic signed [WORD_BITS+HALF_BITS:0]  p0_ff, p0_in;
   logic signed [WORD_BITS+HI_BITS-1:0]  p1_ff, p1_in;
   logic signed [PROD_BITS-1:0]          full_ff, full_in;

   logic signed [HALF_BITS:0]            lo_s;
   logic signed [HI_BITS-1:0]            hi_s;
   logic signed [PROD_BITS-1:0]          rnd;
   logic [PROD_BITS-FRAC_BITS-1:0]       shifted;
   logic [PROD_BITS-FRAC_BITS-WORD_BITS:0] hi_chk;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         MP_IDLE: if (start) phase_in = MP_LO;
         MP_LO:   phase_in = MP_HI;
         MP_HI:   phase_in = MP_SUM;
         MP_SUM:  phase_in = MP_OUT;
         MP_OUT:  phase_in = MP_IDLE;
         default: phase_in = MP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // low half of b is unsigned, high half carries the sign
   always_comb begin
      lo_s    = $signed({1'b0, b_ff[HALF_BITS-1:0]});
      hi_s    = $signed(b_ff[WORD_BITS-1:HALF_BITS]);
      p0_in   = a_ff * lo_s;
      p1_in   = a_ff * hi_s;
      full_in = PROD_BITS'(p0_ff) + (PROD_BITS'(p1_ff) <<< HALF_BITS);
   end

   always_ff @(posedge clock) begin
      if (start && phase_ff == MP_IDLE) begin
         a_ff <= opnd_a;
         b_ff <= opnd_b;
      end
      if (phase_ff == MP_LO)  p0_ff   <= p0_in;
      if (phase_ff == MP_HI)  p1_ff   <= p1_in;
      if (phase_ff == MP_SUM) full_ff <= full_in;
   end

   // round half up, then clamp to the word range
   always_comb begin
      rnd     = full_ff + (PROD_BITS'(1) <<< (FRAC_BITS - 1));
      shifted = rnd[PROD_BITS-1:FRAC_BITS];
      hi_chk  = shifted[PROD_BITS-FRAC_BITS-1:WORD_BITS-1];
      sat     = !((&hi_chk) || !(|hi_chk));
      if (sat) begin
         result = shifted[PROD_BITS-FRAC_BITS-1] ? WORD_MIN : WORD_MAX;
      end else begin
         result = word_type'(shifted[WORD_BITS-1:0]);
      end
   end

   assign done = (phase_ff == MP_OUT);

endmodule

`default_nettype wire

// ----- hdl/lrk_div6.sv -----
// Divide by six, rounded to nearest with ties upward, one nibble per cycle.
// Depends on lrk_pkg. Result and done are valid the cycle after the last step.
`default_nettype none

module lrk_div6 (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire lrk_pkg::word_type value,
   output logic                   done,
   output lrk_pkg::word_type      quot
);
   import lrk_pkg::*;

   // v + 3 + 3*2^W is non-negative; 3*2^W / 6 = 2^(W-1) is removed at the end.
   localparam logic [DIV_BITS-1:0] DIV_OFS =
      (DIV_BITS'(3) << WORD_BITS) + DIV_BITS'(3);

   logic                     busy_ff;
   logic [DIV_CNT_BITS-1:0]  cnt_ff;
   logic [DIV_BITS-1:0]      w_ff, w_in;
   logic [2:0]               rem_ff, rem_in;
   logic [DIV_BITS-1:0]      q_ff, q_in;
   logic [3:0]               digit;
   logic [6:0]               val;

   assign w_in = {{(DIV_BITS-WORD_BITS){value[WORD_BITS-1]}}, value} + DIV_OFS;

   // restoring radix-16 step: remainder stays below six
   always_comb begin
      val = {rem_ff, w_ff[DIV_BITS-1 -: 4]};
      for (int i = 3; i >= 0; i--) begin
         if (val >= (7'(6) << i)) begin
            digit[i] = 1'b1;
            val      = val - (7'(6) << i);
         end else begin
            digit[i] = 1'b0;
         end
      end
      rem_in = val[2:0];
      q_in   = {q_ff[DIV_BITS-5:0], digit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         w_ff   <= w_in;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff && cnt_ff != DIV_CNT_BITS'(DIV_STEPS)) begin
         w_ff   <= w_ff << 4;
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign done = busy_ff && (cnt_ff == DIV_CNT_BITS'(DIV_STEPS));
   assign quot = word_type'({~q_ff[WORD_BITS-1], q_ff[WORD_BITS-2:0]});

endmodule

`default_nettype wire

// ----- hdl/lorenz_rk4_integrator_unit.sv -----
// Lorenz RK4 integrator: one fourth-order Runge-Kutta step per request word.
// The 80-op microprogram runs one op at a time: 28 multiplies, 3 divides by six and
// 49 add/sub/halve ops (register file read, then execute and write back). A new
// request is taken only after the previous word is loaded into the output register.
// Reset (synchronous): CSRs to defaults, state to the default initial values.
`default_nettype none

module lorenz_rk4_integrator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lrk_req_if.sink                                   req_bus,
   lrk_rsp_if.source                                 rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [lrk_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [lrk_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import lrk_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   step_type step_size_ff;
   word_type init_x_ff, init_y_ff, init_z_ff;
   word_type sigma_ff, rho_ff, beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= RST_STEP_SIZE;
         init_x_ff    <= RST_INIT_X;
         init_y_ff    <= RST_INIT_Y;
         init_z_ff    <= RST_INIT_Z;
         sigma_ff     <= RST_SIGMA;
         rho_ff       <= RST_RHO;
         beta_ff      <= RST_BETA;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_STEP_SIZE: step_size_ff <= csr_wdata[STEP_BITS-1:0];
            CSR_INIT_X:    init_x_ff    <= word_type'(csr_wdata);
            CSR_INIT_Y:    init_y_ff    <= word_type'(csr_wdata);
            CSR_INIT_Z:    init_z_ff    <= word_type'(csr_wdata);
            CSR_SIGMA:     sigma_ff     <= word_type'(csr_wdata);
            CSR_RHO:       rho_ff       <= word_type'(csr_wdata);
            CSR_BETA:      beta_ff      <= word_type'(csr_wdata);
            default: ;     // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [PC_BITS-1:0]   pc_ff;
   uop_type              uop;
   logic                 pc_last;

   // control decoded from state
   logic       req_ready;
   logic       rf_rd_en;
   logic       mul_start;
   logic       div_start;
   logic       wr_en;
   logic       rsp_load;
   logic       unit_done;
   logic       is_long_op;
   logic       req_accept;

   assign uop        = PROG[pc_ff];
   assign pc_last    = (pc_ff == PC_BITS'(PROG_LEN - 1));
   assign is_long_op = (uop.opc == OPC_MUL) || (uop.opc == OPC_SIXTH);
   assign req_accept = req_bus.valid && req_ready;

   // ---------------------------------------------------------------------
   // Architectural state and result register
   // ---------------------------------------------------------------------
   word_type pos_x_ff, pos_y_ff, pos_z_ff;
   logic     ovf_ff;
   logic     rsp_valid_ff;
   word_type rsp_x_out_ff, rsp_y_out_ff, rsp_z_out_ff;
   logic     rsp_overflow_ff;

   // ---------------------------------------------------------------------
   // Operand fetch: scratch file or fixed sources
   // ---------------------------------------------------------------------
   rf_ctl_type rf_ctl;
   word_type   rf_rdata_a, rf_rdata_b;
   word_type   opnd_a, opnd_b;
   word_type   h_word;

   assign h_word = word_type'({{(WORD_BITS-STEP_BITS){1'b0}}, step_size_ff});

   always_comb begin
      case (uop.src_a)
         LOC_POSX:  opnd_a = pos_x_ff;
         LOC_POSY:  opnd_a = pos_y_ff;
         LOC_POSZ:  opnd_a = pos_z_ff;
         LOC_SIGMA: opnd_a = sigma_ff;
         LOC_RHO:   opnd_a = rho_ff;
         LOC_BETA:  opnd_a = beta_ff;
         LOC_H:     opnd_a = h_word;
         default:   opnd_a = rf_rdata_a;
      endcase
      case (uop.src_b)
         LOC_POSX:  opnd_b = pos_x_ff;
         LOC_POSY:  opnd_b = pos_y_ff;
         LOC_POSZ:  opnd_b = pos_z_ff;
         LOC_SIGMA: opnd_b = sigma_ff;
         LOC_RHO:   opnd_b = rho_ff;
         LOC_BETA:  opnd_b = beta_ff;
         LOC_H:     opnd_b = h_word;
         default:   opnd_b = rf_rdata_b;
      endcase
   end

   // ---------------------------------------------------------------------
   // Combinational ops: saturating add/sub, halve (round half up)
   // ---------------------------------------------------------------------
   logic signed [WORD_BITS:0] add_sum, sub_sum, half_sum;
   word_type                  add_res, sub_res, half_res, alu_res;
   logic                      add_sat, sub_sat, alu_sat;

   always_comb begin
      add_sum  = {opnd_a[WORD_BITS-1], opnd_a} + {opnd_b[WORD_BITS-1], opnd_b};
      sub_sum  = {opnd_a[WORD_BITS-1], opnd_a} - {opnd_b[WORD_BITS-1], opnd_b};
      half_sum = {opnd_a[WORD_BITS-1], opnd_a} + (WORD_BITS+1)'(1);
      add_sat  = add_sum[WORD_BITS] != add_sum[WORD_BITS-1];
      sub_sat  = sub_sum[WORD_BITS] != sub_sum[WORD_BITS-1];
      add_res  = add_sat ? (add_sum[WORD_BITS] ? WORD_MIN : WORD_MAX)
                         : word_type'(add_sum[WORD_BITS-1:0]);
      sub_res  = sub_sat ? (sub_sum[WORD_BITS] ? WORD_MIN : WORD_MAX)
                         : word_type'(sub_sum[WORD_BITS-1:0]);
      half_res = word_type'(half_sum[WORD_BITS:1]);
      case (uop.opc)
         OPC_ADD: begin
            alu_res = add_res;
            alu_sat = add_sat;
         end
         OPC_SUB: begin
            alu_res = sub_res;
            alu_sat = sub_sat;
         end
         default: begin
            alu_res = half_res;
            alu_sat = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Multi-cycle units
   // ---------------------------------------------------------------------
   logic     mul_done, mul_sat, div_done;
   word_type mul_res, div_res;

   lrk_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   lrk_div6 u_div6 (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .value (opnd_a),
      .done  (div_done),
      .quot  (div_res)
   );

   assign unit_done = (uop.opc == OPC_MUL) ? mul_done : div_done;

   // ---------------------------------------------------------------------
   // Write back
   // ---------------------------------------------------------------------
   word_type wr_data;
   logic     wr_sat;

   always_comb begin
      if (state_ff == ST_EXEC) begin
         wr_data = alu_res;
         wr_sat  = alu_sat;
      end else if (uop.opc == OPC_MUL) begin
         wr_data = mul_res;
         wr_sat  = mul_sat;
      end else begin
         wr_data = div_res;
         wr_sat  = 1'b0;
      end
   end

   always_comb begin
      rf_ctl.rd_en   = rf_rd_en;
      rf_ctl.raddr_a = uop.src_a[RF_ADDR_BITS-1:0];
      rf_ctl.raddr_b = uop.src_b[RF_ADDR_BITS-1:0];
      rf_ctl.we      = wr_en && is_rf_loc(uop.dst);
      rf_ctl.waddr   = uop.dst[RF_ADDR_BITS-1:0];
   end

   lrk_regfile u_regfile (
      .clock   (clock),
      .ctl     (rf_ctl),
      .wdata   (wr_data),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   // ---------------------------------------------------------------------
   // FSM: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_bus.valid) state_in = ST_ISSUE;
         ST_ISSUE: state_in = ST_EXEC;
         ST_EXEC: begin
            if (is_long_op)   state_in = ST_WAIT;
            else if (pc_last) state_in = ST_DONE;
            else              state_in = ST_ISSUE;
         end
         ST_WAIT: begin
            if (unit_done) state_in = pc_last ? ST_DONE : ST_ISSUE;
         end
         ST_DONE: if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // FSM: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      rf_rd_en  = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_ISSUE: rf_rd_en  = 1'b1;
         ST_EXEC: begin
            mul_start = (uop.opc == OPC_MUL);
            div_start = (uop.opc == OPC_SIXTH);
            wr_en     = !is_long_op;
         end
         ST_WAIT:  wr_en    = unit_done;
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   assign req_bus.ready = req_ready;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            pc_ff <= pc_last ? '0 : pc_ff + 1'b1;
         end
      end
   end

   // state: restart reload on accept, final update from the microprogram
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= RST_INIT_X;
         pos_y_ff <= RST_INIT_Y;
         pos_z_ff <= RST_INIT_Z;
         ovf_ff   <= 1'b0;
      end else if (req_accept) begin
         if (req_bus.restart) begin
            pos_x_ff <= init_x_ff;
            pos_y_ff <= init_y_ff;
            pos_z_ff <= init_z_ff;
         end
         ovf_ff <= 1'b0;
      end else if (wr_en) begin
         if (uop.dst == LOC_POSX) pos_x_ff <= wr_data;
         if (uop.dst == LOC_POSY) pos_y_ff <= wr_data;
         if (uop.dst == LOC_POSZ) pos_z_ff <= wr_data;
         if (wr_sat) ovf_ff <= 1'b1;
      end
   end

   // output register; the next step runs while this word waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_out_ff    <= pos_x_ff;
         rsp_y_out_ff    <= pos_y_ff;
         rsp_z_out_ff    <= pos_z_ff;
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.x_out    = rsp_x_out_ff;
   assign rsp_bus.y_out    = rsp_y_out_ff;
   assign rsp_bus.z_out    = rsp_z_out_ff;
   assign rsp_bus.overflow = rsp_overflow_ff;

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff == ST_ISSUE)
      else $error("accepted word did not start the microprogram");

   a_unit_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done) |-> state_ff == ST_WAIT)
      else $error("arithmetic unit finished outside the wait state");

   a_idle_pc_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> pc_ff == '0)
      else $error("program counter not rewound at idle");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for lorenz_rk4_integrator_unit: a scoreboard class steps its own
// saturating Q16.32 copy of the Lorenz system and checks every response word.
// Depends on lrk_pkg, lrk_req_if, lrk_rsp_if and the unit itself.

module tb;
   import lrk_pkg::*;

   // Saturation bounds of the 48-bit word, held in 64-bit signed arithmetic.
   localparam longint SAT_HI = longint'(WORD_MAX);
   localparam longint SAT_LO = longint'(WORD_MIN);
   // Index 7 decodes to no register; writes to it must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NONE = 3'd7;
   localparam int RANDOM_WORDS = 450;
   localparam int LONG_HOLD    = 2000;   // longer than a step, so the unit backs up
   localparam int TAIL_CYCLES  = 400;    // longer than the step latency

   typedef struct {
      word_type x;
      word_type y;
      word_type z;
      logic     ovf;
   } rk4_word_type;

   // Scoreboard: register copy, Lorenz state, and queue of predicted words.
   class lorenz_tracker;
      step_type     h_reg;
      word_type     init_x, init_y, init_z, sigma, rho, beta;
      longint       pos_x, pos_y, pos_z;
      bit           clipped;
      rk4_word_type stepped_states[$];
      int           errors;
      int           n_checked;

      function new();
         h_reg  = RST_STEP_SIZE;
         init_x = RST_INIT_X;
         init_y = RST_INIT_Y;
         init_z = RST_INIT_Z;
         sigma  = RST_SIGMA;
         rho    = RST_RHO;
         beta   = RST_BETA;
         pos_x  = init_x;
         pos_y  = init_y;
         pos_z  = init_z;
         errors = 0;
         n_checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            CSR_STEP_SIZE: h_reg  = v[STEP_BITS-1:0];
            CSR_INIT_X:    init_x = v;
            CSR_INIT_Y:    init_y = v;
            CSR_INIT_Z:    init_z = v;
            CSR_SIGMA:     sigma  = v;
            CSR_RHO:       rho    = v;
            CSR_BETA:      beta   = v;
            default: ;
         endcase
      endfunction

      function longint clip(longint v);
         if (v > SAT_HI) begin
            clipped = 1'b1;
            return SAT_HI;
         end
         if (v < SAT_LO) begin
            clipped = 1'b1;
            return SAT_LO;
         end
         return v;
      endfunction

      function longint sadd(longint a, longint b);
         return clip(a + b);
      endfunction

      function longint ssub(longint a, longint b);
         return clip(a - b);
      endfunction

      // exact product, >> FRAC_BITS, round half up, saturate
      function longint smul(longint a, longint b);
         logic signed [127:0] wa, wb, wide;
         wa = a;
         wb = b;
         wide = ((wa * wb) + 128'sd2147483648) >>> FRAC_BITS;
         if (wide > SAT_HI) begin
            clipped = 1'b1;
            return SAT_HI;
         end
         if (wide < SAT_LO) begin
            clipped = 1'b1;
            return SAT_LO;
         end
         return wide[63:0];
      endfunction

      // v / d rounded to nearest, ties toward +inf: floor((2v + d) / 2d)
      function longint rnd_div(longint v, longint d);
         longint n, m, q;
         n = 2 * v + d;
         m = 2 * d;
         q = n / m;
         if ((n % m) < 0) q = q - 1;
         return q;
      endfunction

      function void slope(longint x, longint y, longint z,
                          output longint dx, output longint dy, output longint dz);
         dx = smul(sigma, ssub(y, x));
         dy = ssub(smul(x, ssub(rho, z)), y);
         dz = ssub(smul(x, y), smul(beta, z));
      endfunction

      function rk4_word_type rk4_step(bit restart);
         longint       h, dx, dy, dz, qx, qy, qz;
         longint       kx[4], ky[4], kz[4];
         rk4_word_type r;
         clipped = 1'b0;
         if (restart) begin
            pos_x = init_x;
            pos_y = init_y;
            pos_z = init_z;
         end
         h  = longint'(h_reg);
         qx = pos_x;
         qy = pos_y;
         qz = pos_z;
         for (int s = 0; s < 4; s++) begin
            slope(qx, qy, qz, dx, dy, dz);
            kx[s] = smul(h, dx);
            ky[s] = smul(h, dy);
            kz[s] = smul(h, dz);
            if (s < 2) begin
               qx = sadd(pos_x, rnd_div(kx[s], 2));
               qy = sadd(pos_y, rnd_div(ky[s], 2));
               qz = sadd(pos_z, rnd_div(kz[s], 2));
            end else begin
               qx = sadd(pos_x, kx[s]);
               qy = sadd(pos_y, ky[s]);
               qz = sadd(pos_z, kz[s]);
            end
         end
         pos_x = sadd(pos_x, rnd_div(sadd(sadd(kx[0], sadd(kx[1], kx[1])),
                                          sadd(sadd(kx[2], kx[2]), kx[3])), 6));
         pos_y = sadd(pos_y, rnd_div(sadd(sadd(ky[0], sadd(ky[1], ky[1])),
                                          sadd(sadd(ky[2], ky[2]), ky[3])), 6));
         pos_z = sadd(pos_z, rnd_div(sadd(sadd(kz[0], sadd(kz[1], kz[1])),
                                          sadd(sadd(kz[2], kz[2]), kz[3])), 6));
         r.x   = pos_x[WORD_BITS-1:0];
         r.y   = pos_y[WORD_BITS-1:0];
         r.z   = pos_z[WORD_BITS-1:0];
         r.ovf = clipped;
         return r;
      endfunction

      function void note_word(bit restart);
         stepped_states.push_back(rk4_step(restart));
      endfunction

      function int pending();
         return stepped_states.size();
      endfunction

      // one line per mismatch
      task report(string msg);
         $display("ERROR word %0d: %s", n_checked, msg);
         errors++;
      endtask

      task check_word(word_type x, word_type y, word_type z, logic ovf);
         rk4_word_type want;
         if (stepped_states.size() == 0) begin
            report($sformatf("response with none pending, x_out %h", x));
            return;
         end
         want = stepped_states.pop_front();
         if (x !== want.x) report($sformatf("x_out %h, want %h", x, want.x));
         if (y !== want.y) report($sformatf("y_out %h, want %h", y, want.y));
         if (z !== want.z) report($sformatf("z_out %h, want %h", z, want.z));
         if (ovf !== want.ovf) report($sformatf("overflow %b, want %b", ovf, want.ovf));
         n_checked++;
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   lrk_req_if req_bus();
   lrk_rsp_if rsp_bus();

   lorenz_tracker track;
   bit req_eager;      // sender offers back to back
   bit rsp_eager;      // receiver adds no random stalls
   int rsp_hold;       // one-shot long receiver stall, in cycles

   lorenz_rk4_integrator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap(bit eager);
      return eager ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] q32(real r);
      longint v;
      v = longint'(r * 4294967296.0);
      return v[CSR_DATA_BITS-1:0];
   endfunction

   // uniform real in [-span, span]
   function automatic real spread(real span);
      return (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0 * span;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] any48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[CSR_DATA_BITS-1:0];
   endfunction

   // a few LSBs to a few units: plenty of odd values for the rounding paths
   function automatic logic [CSR_DATA_BITS-1:0] near_zero();
      longint v;
      v = longint'($urandom) <<< $urandom_range(0, 3);
      if ($urandom_range(0, 1)) v = -v;
      return v[CSR_DATA_BITS-1:0];
   endfunction

   // CSR writes happen only with the unit idle; model is updated on the spot.
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      track.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic load_regs(logic [CSR_DATA_BITS-1:0] h, ix, iy, iz, sg, rh, bt);
      write_reg(CSR_STEP_SIZE, h);
      write_reg(CSR_INIT_X, ix);
      write_reg(CSR_INIT_Y, iy);
      write_reg(CSR_INIT_Z, iz);
      write_reg(CSR_SIGMA, sg);
      write_reg(CSR_RHO, rh);
      write_reg(CSR_BETA, bt);
   endtask

   // One request word; called at a rising edge, returns at its accept edge.
   task automatic send_word(bit rs);
      int gap;
      gap = pick_gap(req_eager);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= rs;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track.note_word(rs);
   endtask

   // Drop valid and hold off until every predicted word is back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (track.pending() != 0) @(posedge clock);
   endtask

   // Directed burst: restart flags taken from pattern, LSB first.
   task automatic burst(logic [7:0] pattern, int n);
      for (int i = 0; i < n; i++) send_word(pattern[i]);
      drain();
   endtask

   // Response side: random stalls per word, plus the one long hold-off.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = pick_gap(rsp_eager);
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         track.check_word(rsp_bus.x_out, rsp_bus.y_out, rsp_bus.z_out, rsp_bus.overflow);
      end
   end

   initial begin
      int left;
      int n;
      int phase;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      req_eager       = 1'b0;
      rsp_eager       = 1'b0;
      rsp_hold        = 0;
      track           = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: step from the reset state, then a restart mid-run.
      burst(8'b0100, 4);

      // Largest h, every init and coefficient at a word extreme: saturates all over.
      load_regs(48'hFFFF_FFFF_FFFF, WORD_MAX, WORD_MIN, WORD_MAX,
                WORD_MAX, WORD_MIN, WORD_MAX);
      burst(8'b01, 2);
      load_regs(48'h7FFF_FFFF_FFFF, WORD_MIN, WORD_MAX, WORD_MIN,
                WORD_MIN, WORD_MAX, WORD_MIN);
      burst(8'b01, 2);

      // Everything zero; bit 47 of the step write is dropped, so h is zero too.
      load_regs(48'h8000_0000_0000, '0, '0, '0, '0, '0, '0);
      burst(8'b01, 2);

      // Write to the unused index: must change nothing.
      write_reg(CSR_NONE, '1);
      burst(8'b0, 1);

      // One-LSB step and state, half-unit coefficients: rounding ties.
      load_regs(48'd1, '1, 48'd1, '1, q32(0.5), q32(-0.5), q32(1.5));
      burst(8'b001, 3);

      // Classic attractor with a coarse step.
      load_regs(q32(0.01), q32(1.0), q32(1.0), q32(1.0), RST_SIGMA, RST_RHO, RST_BETA);
      burst(8'b00001, 5);

      // Random phases: usually a fresh register profile, then a burst of words, drain.
      left  = RANDOM_WORDS;
      phase = 0;
      while (left > 0) begin
         n = $urandom_range(8, 40);
         if (n > left) n = left;
         req_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: load_regs(48'($urandom_range(1, 1 << 24)),
                         q32(spread(20.0)), q32(spread(20.0)), q32(25.0 + spread(20.0)),
                         q32(10.0 + spread(2.0)), q32(28.0 + spread(4.0)),
                         q32(8.0 / 3.0 + spread(0.5)));
            1: load_regs(any48(), any48(), any48(), any48(), any48(), any48(), any48());
            2: load_regs(48'($urandom), near_zero(), near_zero(), near_zero(),
                         near_zero(), near_zero(), near_zero());
            default: ;
         endcase
         // Third phase: receiver parks long enough for the unit to back up
         // and stall the request side while the sender keeps offering.
         if (phase == 2) begin
            rsp_hold  = LONG_HOLD;
            req_eager = 1'b1;
            if (n < 20 && left >= 20) n = 20;
         end
         for (int i = 0; i < n; i++)
            send_word(i == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0));
         drain();
         left = left - n;
         phase++;
      end

      // Catch any stray response after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (track.errors == 0)
         $display("lorenz_rk4_integrator_unit: match");
      else
         $display("lorenz_rk4_integrator_unit: mismatch");
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #12_000_000;
      $display("lorenz_rk4_integrator_unit: mismatch");
      $finish;
   end

endmodule
